FILE: src/sbeq_pkg.sv
// shared types and constants of the six band equalizer
`default_nettype none
package sbeq_pkg;

   // fixed field widths
   localparam int SAMPLE_WIDTH      = 16;
   localparam int COEF_WIDTH        = 24;
   localparam int STATE_WIDTH       = 32;
   localparam int GAIN_WIDTH        = 16;
   localparam int STATE_FRAC        = 8;
   localparam int GAIN_FRAC         = 12;
   localparam int COEFS_PER_SECTION = 5;
   localparam int NUM_GAINS         = 6;
   localparam int ACC_WIDTH         = 64;
   localparam int PROD_WIDTH        = COEF_WIDTH + STATE_WIDTH;
   localparam int BAND_W            = 3;
   localparam int SEC_W             = 4;
   localparam int STEP_W            = 4;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 16;
   localparam int NOISE_LEVEL       = 8000;

   localparam logic [15:0] NOISE_SEED = 16'hFFFF;
   localparam logic signed [STATE_WIDTH-1:0] NOISE_X =
      STATE_WIDTH'(NOISE_LEVEL * (2 ** STATE_FRAC));
   localparam logic [SEC_W-1:0] SECTIONS_RESET = SEC_W'(8);
   localparam logic signed [GAIN_WIDTH-1:0] GAIN_UNITY = GAIN_WIDTH'(2 ** GAIN_FRAC);

   // item operations
   localparam logic OP_PROCESS = 1'b0;
   localparam logic OP_LOAD    = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_SELECT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTIONS        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_LOW_PASS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_BAND_ONE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_BAND_TWO   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_BAND_THREE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_BAND_FOUR  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_HIGH_PASS  = 3'd7;

   // coefficient slots within a section
   localparam logic [2:0] COEF_A1 = 3'd0;
   localparam logic [2:0] COEF_A2 = 3'd1;
   localparam logic [2:0] COEF_B0 = 3'd2;
   localparam logic [2:0] COEF_B1 = 3'd3;
   localparam logic [2:0] COEF_B2 = 3'd4;

   typedef struct packed {
      logic                     operation;
      logic [SAMPLE_WIDTH-1:0]  sample_in;
      logic [2:0]               band;
      logic [2:0]               section_index;
      logic [2:0]               coef_index;
      logic [COEF_WIDTH-1:0]    coef_value;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0]  sample_out;
      logic                     clipped;
   } rsp_type;

   typedef enum logic [2:0] {
      MUL_A1_D0,
      MUL_A2_D1,
      MUL_B0_W,
      MUL_B1_D0,
      MUL_B2_D1,
      MUL_Y_GAIN
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_X,
      ACC_SUB,
      ACC_ADD,
      ACC_LOAD_PROD
   } acc_op_type;

   typedef struct packed {
      logic              start;
      logic              load;
      logic [BAND_W-1:0] band;
      logic [SEC_W-1:0]  sec;
      logic [2:0]        coef_sel;
      logic              cap_en;
      logic [2:0]        cap_sel;
      logic              cap_delay;
      mul_sel_type       mul_sel;
      acc_op_type        acc_op;
      logic              take_w;
      logic              take_y;
      logic              band_start;
      logic              sum_add;
      logic              finish;
   } dp_cmd_type;

   typedef struct packed {
      logic [SEC_W-1:0] sections;
      logic             out_free;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: src/six_band_biquad_equalizer.sv
// top level of the six band cascaded biquad equalizer
//
//   channel   direction   handshake              payload
//   req       in          req_valid/req_ready    req_data (req_type)
//   rsp       out         rsp_valid/rsp_ready    rsp_data (rsp_type)
//   csr       in          csr_valid/csr_ready    csr_index, csr_data
//
// a coefficient load gives no result.
// a sample runs through the set sections of each band in turn on the one shared multiplier,
// with one coefficient read per cycle.
// reset clears the delay row valid bits; no clearing pass is needed.
// the result waits in an output register; a new item is taken while it is held,
// and only the final write of the next result waits for it to be taken.
`default_nettype none
module six_band_biquad_equalizer #(
   parameter int NUM_BANDS      = 6,
   parameter int MAX_SECTIONS   = 8,
   parameter int COEF_FRAC_BITS = 20
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire sbeq_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output sbeq_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [sbeq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [sbeq_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sbeq_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // registers are always writable
   assign csr_ready = 1'b1;

   sbeq_ctrl #(
      .NUM_BANDS    (NUM_BANDS),
      .MAX_SECTIONS (MAX_SECTIONS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   sbeq_datapath #(
      .NUM_BANDS      (NUM_BANDS),
      .MAX_SECTIONS   (MAX_SECTIONS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: src/sbeq_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module sbeq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/sbeq_datapath.sv
// equalizer datapath: stores, shared multiplier, accumulators, output register
`default_nettype none
module sbeq_datapath #(
   parameter int NUM_BANDS      = 6,
   parameter int MAX_SECTIONS   = 8,
   parameter int COEF_FRAC_BITS = 20
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire sbeq_pkg::req_type                    req_data,
   input  wire logic                                 csr_valid,
   input  wire logic [sbeq_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [sbeq_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire sbeq_pkg::dp_cmd_type                 cmd,
   output sbeq_pkg::dp_status_type                   status,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output sbeq_pkg::rsp_type                         rsp_data
);
   import sbeq_pkg::*;

   localparam int COEF_DEPTH = NUM_BANDS * MAX_SECTIONS * COEFS_PER_SECTION;
   localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
   localparam int ROWS       = NUM_BANDS * MAX_SECTIONS;
   localparam int ROW_AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int OUT_SHIFT  = STATE_FRAC + GAIN_FRAC;
   localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF =
      ACC_WIDTH'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_WIDTH-1:0] STATE_MAX = ACC_WIDTH'(2147483647);
   localparam logic signed [ACC_WIDTH-1:0] STATE_MIN = -(ACC_WIDTH'(2147483647)) - 1;
   localparam logic [ACC_WIDTH-1:0] OUT_POS_LIMIT = ACC_WIDTH'(2 ** (SAMPLE_WIDTH - 1) - 1);
   localparam logic [ACC_WIDTH-1:0] OUT_NEG_LIMIT = ACC_WIDTH'(2 ** (SAMPLE_WIDTH - 1));
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // rounding by the coefficient fraction with saturation to the state width
   function automatic logic signed [STATE_WIDTH-1:0] round_sat(
      input logic signed [ACC_WIDTH-1:0] a);
      logic signed [ACC_WIDTH-1:0] t;
      t = (a + ROUND_HALF) >>> COEF_FRAC_BITS;
      if (t > STATE_MAX) begin
         round_sat = STATE_MAX[STATE_WIDTH-1:0];
      end else if (t < STATE_MIN) begin
         round_sat = STATE_MIN[STATE_WIDTH-1:0];
      end else begin
         round_sat = t[STATE_WIDTH-1:0];
      end
   endfunction

   // configuration registers
   logic                          source_ff;
   logic [SEC_W-1:0]              sections_ff;
   logic signed [GAIN_WIDTH-1:0]  gain_ff [NUM_GAINS];

   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff   <= 1'b0;
         sections_ff <= SECTIONS_RESET;
         for (int i = 0; i < NUM_GAINS; i++) begin
            gain_ff[i] <= GAIN_UNITY;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SOURCE_SELECT:   source_ff   <= csr_data[0];
            CSR_SECTIONS:        sections_ff <= csr_data[SEC_W-1:0];
            CSR_GAIN_LOW_PASS:   gain_ff[0]  <= csr_data;
            CSR_GAIN_BAND_ONE:   gain_ff[1]  <= csr_data;
            CSR_GAIN_BAND_TWO:   gain_ff[2]  <= csr_data;
            CSR_GAIN_BAND_THREE: gain_ff[3]  <= csr_data;
            CSR_GAIN_BAND_FOUR:  gain_ff[4]  <= csr_data;
            CSR_GAIN_HIGH_PASS:  gain_ff[5]  <= csr_data;
            default: ;
         endcase
      end
   end

   // coefficient store addressing
   logic                   load_ok;
   logic [COEF_AW-1:0]     coef_wr_addr;
   logic [COEF_AW-1:0]     coef_rd_addr;
   logic [COEF_WIDTH-1:0]  coef_rd;
   logic [ROW_AW-1:0]      row;

   always_comb begin
      load_ok = cmd.load
         && (32'(req_data.band) < NUM_BANDS)
         && (32'(req_data.section_index) < MAX_SECTIONS)
         && (32'(req_data.coef_index) < COEFS_PER_SECTION);
      coef_wr_addr = COEF_AW'((32'(req_data.band) * MAX_SECTIONS
         + 32'(req_data.section_index)) * COEFS_PER_SECTION + 32'(req_data.coef_index));
      coef_rd_addr = COEF_AW'((32'(cmd.band) * MAX_SECTIONS + 32'(cmd.sec))
         * COEFS_PER_SECTION + 32'(cmd.coef_sel));
      row = ROW_AW'(32'(cmd.band) * MAX_SECTIONS + 32'(cmd.sec));
   end

   sbeq_ram #(.WIDTH(COEF_WIDTH), .DEPTH(COEF_DEPTH)) u_coef_ram (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (coef_wr_addr),
      .wr_data (req_data.coef_value),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd)
   );

   // delay store: one row per section, d1 high and d0 low
   logic signed [STATE_WIDTH-1:0]   d0_ff, d1_ff, w_ff, x_ff, x0_ff;
   logic [2*STATE_WIDTH-1:0]        delay_rd;
   logic [ROWS-1:0]                 valid_ff;
   logic                            row_valid_ff;

   sbeq_ram #(.WIDTH(2 * STATE_WIDTH), .DEPTH(ROWS)) u_delay_ram (
      .clock   (clock),
      .wr_en   (cmd.take_y),
      .wr_addr (row),
      .wr_data ({d0_ff, w_ff}),
      .rd_addr (row),
      .rd_data (delay_rd)
   );

   // row valid bits, cleared at reset so unwritten rows read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.take_y) begin
         valid_ff[row] <= 1'b1;
      end
      row_valid_ff <= valid_ff[row];
   end

   // noise source and first section input
   logic [15:0]                    noise_ff;
   logic                           noise_fb;
   logic signed [STATE_WIDTH-1:0]  x0;

   always_comb begin
      noise_fb = noise_ff[0] ^ noise_ff[1] ^ noise_ff[11] ^ noise_ff[13];
      if (source_ff) begin
         x0 = STATE_WIDTH'($signed(req_data.sample_in)) <<< STATE_FRAC;
      end else begin
         x0 = noise_ff[0] ? -NOISE_X : NOISE_X;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff <= NOISE_SEED;
      end else if (cmd.start && !source_ff) begin
         noise_ff <= {noise_ff[14:0], noise_fb};
      end
   end

   // coefficient capture
   logic signed [COEF_WIDTH-1:0] c_ff [COEFS_PER_SECTION];

   always_ff @(posedge clock) begin
      if (cmd.cap_en) begin
         unique case (cmd.cap_sel)
            COEF_A1: c_ff[0] <= coef_rd;
            COEF_A2: c_ff[1] <= coef_rd;
            COEF_B0: c_ff[2] <= coef_rd;
            COEF_B1: c_ff[3] <= coef_rd;
            COEF_B2: c_ff[4] <= coef_rd;
            default: ;
         endcase
      end
      if (cmd.cap_delay) begin
         d0_ff <= row_valid_ff ? delay_rd[STATE_WIDTH-1:0] : '0;
         d1_ff <= row_valid_ff ? delay_rd[2*STATE_WIDTH-1:STATE_WIDTH] : '0;
      end
   end

   // band gain, unity beyond the programmable bands
   logic signed [GAIN_WIDTH-1:0] gain_sel;

   always_comb begin
      if (32'(cmd.band) < NUM_GAINS) begin
         gain_sel = gain_ff[cmd.band];
      end else begin
         gain_sel = GAIN_UNITY;
      end
   end

   // shared multiplier with registered product
   logic signed [COEF_WIDTH-1:0]  mul_a;
   logic signed [STATE_WIDTH-1:0] mul_b;
   logic signed [PROD_WIDTH-1:0]  prod_ff;

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_A1_D0:  begin mul_a = c_ff[0]; mul_b = d0_ff; end
         MUL_A2_D1:  begin mul_a = c_ff[1]; mul_b = d1_ff; end
         MUL_B0_W:   begin mul_a = c_ff[2]; mul_b = w_ff;  end
         MUL_B1_D0:  begin mul_a = c_ff[3]; mul_b = d0_ff; end
         MUL_B2_D1:  begin mul_a = c_ff[4]; mul_b = d1_ff; end
         MUL_Y_GAIN: begin mul_a = COEF_WIDTH'(gain_sel); mul_b = x_ff; end
         default:    begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // section accumulator, section results and band sum
   logic signed [ACC_WIDTH-1:0] acc_ff, sum_ff;

   always_ff @(posedge clock) begin
      unique case (cmd.acc_op)
         ACC_LOAD_X:    acc_ff <= ACC_WIDTH'(x_ff) <<< COEF_FRAC_BITS;
         ACC_SUB:       acc_ff <= acc_ff - ACC_WIDTH'(prod_ff);
         ACC_ADD:       acc_ff <= acc_ff + ACC_WIDTH'(prod_ff);
         ACC_LOAD_PROD: acc_ff <= ACC_WIDTH'(prod_ff);
         default:       acc_ff <= acc_ff;
      endcase
      if (cmd.take_w) begin
         w_ff <= round_sat(acc_ff);
      end
      if (cmd.start) begin
         x_ff  <= x0;
         x0_ff <= x0;
      end else if (cmd.band_start) begin
         x_ff <= x0_ff;
      end else if (cmd.take_y) begin
         x_ff <= round_sat(acc_ff);
      end
      if (cmd.start) begin
         sum_ff <= '0;
      end else if (cmd.sum_add) begin
         sum_ff <= sum_ff + ACC_WIDTH'(prod_ff);
      end
   end

   // truncate toward zero and saturate the weighted sum
   logic                     sum_neg;
   logic [ACC_WIDTH-1:0]     sum_mag, sum_q;
   rsp_type                  rsp_next;

   always_comb begin
      sum_neg = sum_ff[ACC_WIDTH-1];
      sum_mag = sum_neg ? -sum_ff : sum_ff;
      sum_q   = sum_mag >> OUT_SHIFT;
      if (!sum_neg && (sum_q > OUT_POS_LIMIT)) begin
         rsp_next.sample_out = SAMPLE_MAX;
         rsp_next.clipped    = 1'b1;
      end else if (sum_neg && (sum_q > OUT_NEG_LIMIT)) begin
         rsp_next.sample_out = SAMPLE_MIN;
         rsp_next.clipped    = 1'b1;
      end else begin
         rsp_next.sample_out = sum_neg ? SAMPLE_WIDTH'(-sum_q) : SAMPLE_WIDTH'(sum_q);
         rsp_next.clipped    = 1'b0;
      end
   end

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign status.sections = sections_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

FILE: src/sbeq_ctrl.sv
// equalizer controller: sequences sections, bands and output
`default_nettype none
module sbeq_ctrl #(
   parameter int NUM_BANDS    = 6,
   parameter int MAX_SECTIONS = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_operation,
   output logic                          req_ready,
   input  wire sbeq_pkg::dp_status_type  status,
   output sbeq_pkg::dp_cmd_type          cmd
);
   import sbeq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SEC  = 4'b0010,
      S_GAIN = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   // schedule of one section
   localparam logic [STEP_W-1:0] ST_FETCH  = 4'd0;
   localparam logic [STEP_W-1:0] ST_CAP_A1 = 4'd1;
   localparam logic [STEP_W-1:0] ST_MUL_A1 = 4'd2;
   localparam logic [STEP_W-1:0] ST_MUL_A2 = 4'd3;
   localparam logic [STEP_W-1:0] ST_SUB_A2 = 4'd4;
   localparam logic [STEP_W-1:0] ST_TAKE_W = 4'd5;
   localparam logic [STEP_W-1:0] ST_MUL_B0 = 4'd6;
   localparam logic [STEP_W-1:0] ST_MUL_B1 = 4'd7;
   localparam logic [STEP_W-1:0] ST_MUL_B2 = 4'd8;
   localparam logic [STEP_W-1:0] ST_ADD_B2 = 4'd9;
   localparam logic [STEP_W-1:0] ST_TAKE_Y = 4'd10;
   // schedule of one band gain
   localparam logic [STEP_W-1:0] GS_MUL    = 4'd0;
   localparam logic [STEP_W-1:0] GS_ADD    = 4'd1;

   localparam logic [SEC_W:0]    MAX_SEC_L  = (SEC_W+1)'(MAX_SECTIONS);
   localparam logic [BAND_W-1:0] LAST_BAND  = BAND_W'(NUM_BANDS - 1);

   state_type          state_ff, state_in;
   logic [BAND_W-1:0]  band_ff, band_in;
   logic [SEC_W-1:0]   sec_ff, sec_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [SEC_W:0]     nsec;
   logic               last_sec, last_band, accept;

   // clamp the section count to one through the maximum
   always_comb begin
      if (status.sections == '0) begin
         nsec = (SEC_W+1)'(1);
      end else if ({1'b0, status.sections} > MAX_SEC_L) begin
         nsec = MAX_SEC_L;
      end else begin
         nsec = {1'b0, status.sections};
      end
      last_sec  = ((SEC_W+1)'({1'b0, sec_ff} + 1'b1)) == nsec;
      last_band = band_ff == LAST_BAND;
      req_ready = state_ff == S_IDLE;
      accept    = req_valid && req_ready;
   end

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      band_in  = band_ff;
      sec_in   = sec_ff;
      step_in  = step_ff;
      cmd          = '0;
      cmd.band     = band_ff;
      cmd.sec      = sec_ff;
      cmd.mul_sel  = MUL_A1_D0;
      cmd.acc_op   = ACC_HOLD;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OP_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = S_SEC;
                  band_in   = '0;
                  sec_in    = '0;
                  step_in   = ST_FETCH;
               end
            end
         end
         S_SEC: begin
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               ST_FETCH: begin
                  cmd.coef_sel = COEF_A1;
                  cmd.acc_op   = ACC_LOAD_X;
               end
               ST_CAP_A1: begin
                  cmd.coef_sel  = COEF_A2;
                  cmd.cap_en    = 1'b1;
                  cmd.cap_sel   = COEF_A1;
                  cmd.cap_delay = 1'b1;
               end
               ST_MUL_A1: begin
                  cmd.coef_sel = COEF_B0;
                  cmd.cap_en   = 1'b1;
                  cmd.cap_sel  = COEF_A2;
                  cmd.mul_sel  = MUL_A1_D0;
               end
               ST_MUL_A2: begin
                  cmd.coef_sel = COEF_B1;
                  cmd.cap_en   = 1'b1;
                  cmd.cap_sel  = COEF_B0;
                  cmd.mul_sel  = MUL_A2_D1;
                  cmd.acc_op   = ACC_SUB;
               end
               ST_SUB_A2: begin
                  cmd.coef_sel = COEF_B2;
                  cmd.cap_en   = 1'b1;
                  cmd.cap_sel  = COEF_B1;
                  cmd.acc_op   = ACC_SUB;
               end
               ST_TAKE_W: begin
                  cmd.cap_en  = 1'b1;
                  cmd.cap_sel = COEF_B2;
                  cmd.take_w  = 1'b1;
               end
               ST_MUL_B0: begin
                  cmd.mul_sel = MUL_B0_W;
               end
               ST_MUL_B1: begin
                  cmd.mul_sel = MUL_B1_D0;
                  cmd.acc_op  = ACC_LOAD_PROD;
               end
               ST_MUL_B2: begin
                  cmd.mul_sel = MUL_B2_D1;
                  cmd.acc_op  = ACC_ADD;
               end
               ST_ADD_B2: begin
                  cmd.acc_op = ACC_ADD;
               end
               ST_TAKE_Y: begin
                  cmd.take_y = 1'b1;
                  step_in    = ST_FETCH;
                  if (last_sec) begin
                     state_in = S_GAIN;
                     step_in  = GS_MUL;
                  end else begin
                     sec_in = sec_ff + 1'b1;
                  end
               end
               default: begin
                  step_in = ST_FETCH;
               end
            endcase
         end
         S_GAIN: begin
            if (step_ff == GS_MUL) begin
               cmd.mul_sel = MUL_Y_GAIN;
               step_in     = GS_ADD;
            end else begin
               cmd.sum_add = 1'b1;
               step_in     = ST_FETCH;
               if (last_band) begin
                  state_in = S_OUT;
               end else begin
                  band_in        = band_ff + 1'b1;
                  sec_in         = '0;
                  cmd.band_start = 1'b1;
                  state_in       = S_SEC;
               end
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         band_ff  <= '0;
         sec_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
         sec_ff   <= sec_in;
         step_ff  <= step_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/sbeq_checker.sv
// port level checks of the equalizer and their binding
`default_nettype none
module sbeq_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire sbeq_pkg::req_type                  req_data,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire sbeq_pkg::rsp_type                  rsp_data,
   input wire logic                               csr_valid,
   input wire logic                               csr_ready,
   input wire logic [sbeq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input wire logic [sbeq_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sbeq_pkg::*;

   localparam logic [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a clipped result sits at a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clipped |-> rsp_data.sample_out == OUT_MAX
         || rsp_data.sample_out == OUT_MIN)
      else $error("clipped result not at a limit");

   // a sample transfer occupies the block
   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.operation == OP_PROCESS |=> !req_ready)
      else $error("input taken during sample processing");

   // a coefficient load leaves the block ready in the next cycle and gives no new result
   a_load_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.operation == OP_LOAD |=> req_ready && !rsp_valid
         || req_ready && $past(rsp_valid))
      else $error("load did not return to idle");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind six_band_biquad_equalizer sbeq_checker u_checker (.*);
`default_nettype wire

FILE: tb/six_band_biquad_equalizer_tb.sv
// self-checking testbench of the six band biquad equalizer
`default_nettype none
module six_band_biquad_equalizer_tb;
   import sbeq_pkg::*;

   localparam int BANDS     = 6;
   localparam int SECTIONS  = 8;
   localparam int FRAC      = 20;
   localparam int SETTLE    = 600;
   localparam int LIMIT     = 1_000_000;
   localparam int LONG_HOLD = 3000;

   typedef enum logic {ROW_ITEM, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type               kind;
      req_type                    item;
      logic [CSR_INDEX_W-1:0]     reg_index;
      logic [CSR_DATA_W-1:0]      reg_data;
      bit                         known;
      rsp_type                    known_rsp;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   // equalizer state as predicted
   logic signed [COEF_WIDTH-1:0]  coefs [BANDS*SECTIONS*COEFS_PER_SECTION];
   logic signed [STATE_WIDTH-1:0] delays [BANDS*SECTIONS*2];
   logic [15:0]                   lfsr = NOISE_SEED;
   logic                          use_sample = 1'b0;
   logic [3:0]                    section_count = 4'd8;
   logic signed [GAIN_WIDTH-1:0]  gains [NUM_GAINS];

   rsp_type       expected_q [$];
   stim_row_type  directed_rows [$];
   int            errors = 0;
   int            cycles = 0;
   bit            quiet = 1'b0;
   bit            dirty = 1'b0;
   int            hold_asked = 0;
   int            hold_done = 0;
   int            hold_left = 0;
   int            stall_left = 0;

   six_band_biquad_equalizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // round half up by the coefficient fraction, then saturate to 32 bits
   function automatic logic signed [31:0] round_sat(longint acc);
      longint r;
      r = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
      if (r > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (r < -64'sd2147483648) return 32'sh80000000;
      return r[31:0];
   endfunction

   function automatic void store_coef(req_type it);
      if (it.band < BANDS && it.section_index < SECTIONS && it.coef_index < COEFS_PER_SECTION)
         coefs[(it.band * SECTIONS + it.section_index) * COEFS_PER_SECTION + it.coef_index] =
            it.coef_value;
   endfunction

   // one sample through all bands, weighted sum, saturation
   function automatic rsp_type equalize(logic signed [15:0] smp);
      longint x0, x, acc, sum, q;
      int n, k;
      logic signed [31:0] w;
      rsp_type r;
      if (use_sample) begin
         x0 = smp;
      end else begin
         x0 = lfsr[0] ? -NOISE_LEVEL : NOISE_LEVEL;
         lfsr = {lfsr[14:0], lfsr[0] ^ lfsr[1] ^ lfsr[11] ^ lfsr[13]};
      end
      x0 = x0 * 256;
      n = section_count;
      if (n < 1) n = 1;
      if (n > SECTIONS) n = SECTIONS;
      sum = 0;
      for (int b = 0; b < BANDS; b++) begin
         x = x0;
         for (int s = 0; s < n; s++) begin
            k = b * SECTIONS + s;
            acc = x * (64'sd1 <<< FRAC)
                - longint'(coefs[k*5 + COEF_A1]) * longint'(delays[2*k])
                - longint'(coefs[k*5 + COEF_A2]) * longint'(delays[2*k + 1]);
            w = round_sat(acc);
            acc = longint'(coefs[k*5 + COEF_B0]) * longint'(w)
                + longint'(coefs[k*5 + COEF_B1]) * longint'(delays[2*k])
                + longint'(coefs[k*5 + COEF_B2]) * longint'(delays[2*k + 1]);
            delays[2*k + 1] = delays[2*k];
            delays[2*k] = w;
            x = round_sat(acc);
         end
         sum += x * longint'(gains[b]);
      end
      q = (sum < 0) ? -((-sum) >>> (STATE_FRAC + GAIN_FRAC)) : sum >>> (STATE_FRAC + GAIN_FRAC);
      r.clipped = 1'b0;
      if (q > 32767) begin
         q = 32767;
         r.clipped = 1'b1;
      end
      if (q < -32768) begin
         q = -32768;
         r.clipped = 1'b1;
      end
      r.sample_out = q[15:0];
      return r;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // result side: random stalls, one long hold on request, checking
   always @(posedge clock) begin
      rsp_type e;
      logic nxt;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            report("unexpected result", rsp_data.sample_out, 0);
         end else begin
            e = expected_q.pop_front();
            if (rsp_data.sample_out !== e.sample_out)
               report("sample_out", $signed(rsp_data.sample_out), $signed(e.sample_out));
            if (rsp_data.clipped !== e.clipped)
               report("clipped", rsp_data.clipped, e.clipped);
         end
      end
      if (hold_done != hold_asked) begin
         hold_left = LONG_HOLD;
         hold_done = hold_asked;
      end
      if (hold_left > 0) begin
         hold_left--;
         nxt = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         nxt = 1'b0;
      end else if (!quiet && $urandom_range(4) == 0) begin
         stall_left = $urandom_range(0, 3);
         nxt = 1'b0;
      end else begin
         nxt = 1'b1;
      end
      rsp_ready <= nxt;
   end

   // one input transfer, sometimes with a random gap in front
   task automatic send_item(req_type it, bit known, rsp_type known_rsp);
      rsp_type p;
      csr_valid <= 1'b0;
      if (!quiet && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      dirty = 1'b1;
      if (it.operation == OP_LOAD) begin
         store_coef(it);
      end else begin
         p = equalize(it.sample_in);
         expected_q.push_back(known ? known_rsp : p);
      end
   endtask

   // wait until the block is idle
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      dirty = 1'b0;
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      if (dirty) settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SOURCE_SELECT: use_sample = data[0];
         CSR_SECTIONS:      section_count = data[3:0];
         default:           gains[idx - CSR_GAIN_LOW_PASS] = data;
      endcase
   endtask

   function automatic req_type load_item(int b, int s, int c, logic [23:0] v);
      req_type it;
      it = '0;
      it.operation = OP_LOAD;
      it.sample_in = 16'($urandom);
      it.band = 3'(b);
      it.section_index = 3'(s);
      it.coef_index = 3'(c);
      it.coef_value = v;
      return it;
   endfunction

   function automatic req_type proc_item(logic [15:0] smp);
      req_type it;
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      it = raw[$bits(req_type)-1:0];
      it.operation = OP_PROCESS;
      it.sample_in = smp;
      return it;
   endfunction

   function automatic stim_row_type row_proc(logic [15:0] smp, bit known, int out, bit clip);
      stim_row_type r;
      r = '{ROW_ITEM, proc_item(smp), '0, '0, known, '{16'(out), clip}};
      return r;
   endfunction

   function automatic stim_row_type row_load(int b, int s, int c, logic [23:0] v);
      stim_row_type r;
      r = '{ROW_ITEM, load_item(b, s, c, v), '0, '0, 1'b0, '0};
      return r;
   endfunction

   function automatic stim_row_type row_reg(logic [CSR_INDEX_W-1:0] idx, logic [15:0] data);
      stim_row_type r;
      r = '{ROW_REG, '0, idx, data, 1'b0, '0};
      return r;
   endfunction

   // random item: mostly samples, some coefficient loads, mostly in range with sane values
   function automatic req_type random_item();
      int c;
      logic [23:0] v;
      if ($urandom_range(3) != 0) return proc_item(16'($urandom));
      if ($urandom_range(9) == 0)
         return load_item($urandom_range(0, 7), $urandom_range(0, 7),
                          $urandom_range(0, 7), 24'($urandom));
      c = $urandom_range(0, 4);
      if ($urandom_range(7) == 0)
         v = 24'($urandom);
      else if (c == COEF_A1 || c == COEF_A2)
         v = 24'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      else
         v = 24'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      return load_item($urandom_range(0, BANDS - 1), $urandom_range(0, SECTIONS - 1), c, v);
   endfunction

   initial begin
      stim_row_type row;
      for (int g = 0; g < NUM_GAINS; g++) gains[g] = GAIN_UNITY;
      foreach (delays[i]) delays[i] = '0;
      foreach (coefs[i]) coefs[i] = '0;

      // directed table
      directed_rows.push_back(row_proc(0, 1, -32768, 1));
      directed_rows.push_back(row_proc(0, 1, 32767, 1));
      directed_rows.push_back(row_reg(CSR_SOURCE_SELECT, 16'd1));
      directed_rows.push_back(row_proc(0, 1, 0, 0));
      directed_rows.push_back(row_proc(5000, 1, 30000, 0));
      directed_rows.push_back(row_proc(16'h7FFF, 1, 32767, 1));
      directed_rows.push_back(row_proc(16'h8000, 1, -32768, 1));
      directed_rows.push_back(row_reg(CSR_GAIN_BAND_ONE, 16'd0));
      directed_rows.push_back(row_reg(CSR_GAIN_BAND_TWO, 16'd0));
      directed_rows.push_back(row_reg(CSR_GAIN_BAND_THREE, 16'd0));
      directed_rows.push_back(row_reg(CSR_GAIN_BAND_FOUR, 16'd0));
      directed_rows.push_back(row_reg(CSR_GAIN_HIGH_PASS, 16'd0));
      directed_rows.push_back(row_reg(CSR_GAIN_LOW_PASS, 16'h8000));
      directed_rows.push_back(row_proc(1000, 1, -8000, 0));
      directed_rows.push_back(row_proc(16'hFFFF, 1, 8, 0));
      directed_rows.push_back(row_reg(CSR_GAIN_LOW_PASS, 16'h7FFF));
      // truncation toward zero on a negative sum
      directed_rows.push_back(row_proc(16'hFFFF, 1, -7, 0));
      // loads outside the store are dropped
      directed_rows.push_back(row_load(6, 0, COEF_B0, 24'h7FFFFF));
      directed_rows.push_back(row_load(0, 7, 7, 24'h800000));
      directed_rows.push_back(row_load(7, 7, COEF_B2, 24'h800000));
      directed_rows.push_back(row_proc(1000, 1, 7999, 0));
      // extreme coefficients, section count clamping
      directed_rows.push_back(row_load(0, 0, COEF_A1, 24'h800000));
      directed_rows.push_back(row_load(0, 0, COEF_B0, 24'h7FFFFF));
      directed_rows.push_back(row_reg(CSR_SECTIONS, 16'd0));
      directed_rows.push_back(row_proc(16'h7FFF, 0, 0, 0));
      directed_rows.push_back(row_proc(16'h8000, 0, 0, 0));
      directed_rows.push_back(row_reg(CSR_SECTIONS, 16'd15));
      directed_rows.push_back(row_proc(16'h1234, 0, 0, 0));
      directed_rows.push_back(row_reg(CSR_SECTIONS, 16'd1));
      directed_rows.push_back(row_proc(16'hC000, 0, 0, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // every coefficient starts as a pass-through section
      for (int b = 0; b < BANDS; b++)
         for (int s = 0; s < SECTIONS; s++)
            for (int c = 0; c < COEFS_PER_SECTION; c++)
               send_item(load_item(b, s, c, (c == COEF_B0) ? 24'h100000 : 24'h0), 0, '0);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_REG)
            write_reg(row.reg_index, row.reg_data);
         else
            send_item(row.item, row.known, row.known_rsp);
      end

      // random phases, registers rewritten in between
      for (int ph = 0; ph < 8; ph++) begin
         settle();
         repeat ($urandom_range(1, 3))
            write_reg(3'($urandom_range(0, 7)), 16'($urandom));
         if (ph == 7) quiet = 1'b1;
         for (int n = 0; n < 17; n++) begin
            if (ph == 2 && n == 10) hold_asked++;
            if (ph == 5 && n == 8) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (expected_q.size() != 0);
            end
            send_item(random_item(), 0, '0);
         end
      end

      // drain
      settle();
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire
